// ===== design/rgbpo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbpo_pkg
// Operation codes, filter choices and fixed-point weights for the RGB
// point-operation unit.
// ----------------------------------------------------------------------------
package rgbpo_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned ModeW   = 3;
    localparam int unsigned FiltW   = 4;
    localparam int unsigned WeightW = 9;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgW    = 9;

    typedef logic [ChanW-1:0] chan_t;

    // Operation codes held in op_mode
    localparam logic [ModeW-1:0] OP_PASS     = 3'd0;
    localparam logic [ModeW-1:0] OP_FILTER   = 3'd1;
    localparam logic [ModeW-1:0] OP_NEGATIVE = 3'd2;
    localparam logic [ModeW-1:0] OP_GRAY     = 3'd3;
    localparam logic [ModeW-1:0] OP_SUBTRACT = 3'd4;
    localparam logic [ModeW-1:0] OP_AVERAGE  = 3'd5;
    localparam logic [ModeW-1:0] OP_BLEND    = 3'd6;

    // Filter choices
    localparam logic [FiltW-1:0] FILT_RED     = 4'd1;
    localparam logic [FiltW-1:0] FILT_GREEN   = 4'd2;
    localparam logic [FiltW-1:0] FILT_BLUE    = 4'd3;
    localparam logic [FiltW-1:0] FILT_CYAN    = 4'd4;
    localparam logic [FiltW-1:0] FILT_MAGENTA = 4'd5;
    localparam logic [FiltW-1:0] FILT_YELLOW  = 4'd6;
    localparam logic [FiltW-1:0] FILT_WHITE   = 4'd7;
    localparam logic [FiltW-1:0] FILT_BLACK   = 4'd8;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_OP_MODE      = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_FILTER       = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_VALUE    = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_BLEND_WEIGHT = 8'd3;

    // Luma weights over 65536
    localparam logic [15:0] GRAY_WR = 16'd19595;
    localparam logic [15:0] GRAY_WG = 16'd38470;
    localparam logic [15:0] GRAY_WB = 16'd7471;

    localparam logic [WeightW-1:0] BLEND_ONE = 9'd256;

    // Channel keep mask: bit 0 red, bit 1 green, bit 2 blue
    function automatic logic [2:0] filter_keep(input logic [FiltW-1:0] choice);
        logic [2:0] keep;
        case (choice)
            FILT_RED:     keep = 3'b001;
            FILT_GREEN:   keep = 3'b010;
            FILT_BLUE:    keep = 3'b100;
            FILT_CYAN:    keep = 3'b110;
            FILT_MAGENTA: keep = 3'b101;
            FILT_YELLOW:  keep = 3'b011;
            FILT_WHITE:   keep = 3'b111;
            FILT_BLACK:   keep = 3'b000;
            default:      keep = 3'b111;
        endcase
        return keep;
    endfunction

endpackage
`default_nettype wire

// ===== design/rgb_pixel_point_ops.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_pixel_point_ops
// Per-pixel RGB operation unit: pass, color filter, negative, grayscale,
// subtract, average and blend over a pixel pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_* carries a pixel pair (first and second pixel, 8-bit
//   channels) under s_valid / s_ready. Result channel m_* carries one output
//   pixel per input item under m_valid / m_ready.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata):
//   0 op_mode, 1 filter_choice, 2 max_value, 3 blend_weight; other indexes
//   are ignored. Write registers only while no item is in flight.
//   Pipeline: an accepted input enters the input register, then the result
//   register after one pass of per-channel arithmetic, where it is valid.
//   Throughput: one item per cycle; the pipeline advances whenever the
//   result register is empty or being taken.
//   Reset (aresetn low, synchronous): pipeline emptied, registers return to
//   op_mode 0, filter_choice 7, max_value 255, blend_weight 256.
//   Receiver stall: the result holds in place, the input register still
//   fills, then s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module rgb_pixel_point_ops (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // configuration
    input  wire                                  cfg_wr_en,
    input  wire  [rgbpo_pkg::CfgIdxW-1:0]        cfg_index,
    input  wire  [rgbpo_pkg::CfgW-1:0]           cfg_wdata,
    // input channel
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [rgbpo_pkg::ChanW-1:0]          s_first_red,
    input  wire  [rgbpo_pkg::ChanW-1:0]          s_first_green,
    input  wire  [rgbpo_pkg::ChanW-1:0]          s_first_blue,
    input  wire  [rgbpo_pkg::ChanW-1:0]          s_second_red,
    input  wire  [rgbpo_pkg::ChanW-1:0]          s_second_green,
    input  wire  [rgbpo_pkg::ChanW-1:0]          s_second_blue,
    // result channel
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [rgbpo_pkg::ChanW-1:0]          m_out_red,
    output logic [rgbpo_pkg::ChanW-1:0]          m_out_green,
    output logic [rgbpo_pkg::ChanW-1:0]          m_out_blue
);
    import rgbpo_pkg::*;

    // configuration registers
    logic [ModeW-1:0]   op_mode_reg;
    logic [FiltW-1:0]   filter_choice_reg;
    chan_t              max_value_reg;
    logic [WeightW-1:0] blend_weight_reg;

    // input register
    logic  in_valid_reg;
    chan_t a_reg [3];
    chan_t b_reg [3];

    // result register
    logic  out_valid_reg;
    chan_t r_reg  [3];
    chan_t r_next [3];

    logic advance;
    logic in_take;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg       <= OP_PASS;
            filter_choice_reg <= FILT_WHITE;
            max_value_reg     <= 8'd255;
            blend_weight_reg  <= BLEND_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OP_MODE:      op_mode_reg       <= cfg_wdata[ModeW-1:0];
                REG_FILTER:       filter_choice_reg <= cfg_wdata[FiltW-1:0];
                REG_MAX_VALUE:    max_value_reg     <= cfg_wdata[ChanW-1:0];
                REG_BLEND_WEIGHT: blend_weight_reg  <= cfg_wdata[WeightW-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            a_reg[0] <= s_first_red;
            a_reg[1] <= s_first_green;
            a_reg[2] <= s_first_blue;
            b_reg[0] <= s_second_red;
            b_reg[1] <= s_second_green;
            b_reg[2] <= s_second_blue;
        end
    end

    // per-channel arithmetic
    logic [2:0]         keep;
    logic [23:0]        gray_sum;
    logic [WeightW-1:0] w_sat;
    logic [WeightW-1:0] w_inv;
    logic [16:0]        blend_sum [3];

    assign keep     = filter_keep(filter_choice_reg);
    assign gray_sum = 24'(GRAY_WR) * 24'(a_reg[0]) + 24'(GRAY_WG) * 24'(a_reg[1])
                    + 24'(GRAY_WB) * 24'(a_reg[2]);
    // clamp weights above one to one
    assign w_sat    = (blend_weight_reg > BLEND_ONE) ? BLEND_ONE : blend_weight_reg;
    assign w_inv    = BLEND_ONE - w_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            blend_sum[i] = 17'(w_sat) * 17'(a_reg[i]) + 17'(w_inv) * 17'(b_reg[i]);
            case (op_mode_reg)
                OP_FILTER:   r_next[i] = keep[i] ? a_reg[i] : '0;
                OP_NEGATIVE: r_next[i] = max_value_reg - a_reg[i];
                OP_GRAY:     r_next[i] = gray_sum[23:16];
                OP_SUBTRACT: r_next[i] = (a_reg[i] > b_reg[i]) ? a_reg[i] - b_reg[i] : '0;
                OP_AVERAGE:  r_next[i] = 8'(({1'b0, a_reg[i]} + {1'b0, b_reg[i]}) >> 1);
                OP_BLEND:    r_next[i] = blend_sum[i][15:8];
                default:     r_next[i] = a_reg[i];
            endcase
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            r_reg <= r_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = r_reg[0];
    assign m_out_green = r_reg[1];
    assign m_out_blue  = r_reg[2];

endmodule
`default_nettype wire
